### design/hele_pkg.sv
// Shared types and constants for the histogram-equalisation table builder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hele_pkg;

	localparam int DEF_BINS        = 256;
	localparam int DEF_CHANNELS    = 3;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_W      = 32;

	localparam logic [7:0] OUT_MAX = 8'd255;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RED    = 3'd0,
		REG_MAX_RED    = 3'd1,
		REG_MIN_GREEN  = 3'd2,
		REG_MAX_GREEN  = 3'd3,
		REG_MIN_BLUE   = 3'd4,
		REG_MAX_BLUE   = 3'd5,
		REG_ACTIVE_TOT = 3'd6,
		REG_CHAN_USE   = 3'd7
	} reg_idx_t;

	// Per-cycle memory commands from the sequencer to the store.
	typedef struct packed {
		logic h_rd;
		logic h_wr;
		logic l_rd;
		logic l_wr;
	} store_ctl_t;

endpackage

### design/histogram_equalization_lut_unit.sv
// Top level of the histogram-equalisation table builder: sequencer, config
// registers and result register. Uses hele_pkg, hele_div and hele_store.
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  config  | cfg_we               | cfg_index, cfg_data
//  input   | in_valid / in_ready  | action, channel, pixel_value, bin_index
//  output  | out_valid / out_ready| lut_value, table_ready
//
// One item at a time: a new item is taken only once the last one is done.
// Add: set-up, then the divider when the sample lies strictly inside (min, max),
// then a histogram read and write. Read: a table read request, then the output
// register load. Build: per bin a histogram read, a sum and a table write,
// plus the divider when the running sum is below the pixel total, over every
// channel in use. Clear: all CHANNELS*BINS entries, one entry a cycle.
// After reset the same clearing pass runs before the first item is taken;
// config writes are taken throughout. A waiting result holds the sequencer
// only when the next read wants the output register.
// BINS must be a power of two.

module histogram_equalization_lut_unit #(
	parameter int BINS        = hele_pkg::DEF_BINS,
	parameter int CHANNELS    = hele_pkg::DEF_CHANNELS,
	parameter int COUNT_WIDTH = hele_pkg::DEF_COUNT_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hele_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hele_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [1:0]                     channel,
	input  logic [15:0]                    pixel_value,
	input  logic [7:0]                     bin_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     lut_value,
	output logic                           table_ready
);
	import hele_pkg::*;

	localparam int BW    = $clog2(BINS);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW    = CHW + BW;
	localparam int DEPTH = CHANNELS * BINS;
	localparam int SW    = COUNT_WIDTH + BW;
	localparam int CMPW  = (SW > DIV_W) ? SW : DIV_W;
	localparam int QW    = (BW > 8) ? BW : 8;
	localparam int SCW   = $clog2(QW + 1);

	typedef enum logic [11:0] {
		S_CLEAR   = 12'b000000000001,
		S_IDLE    = 12'b000000000010,
		S_ADD_SET = 12'b000000000100,
		S_ADD_DIV = 12'b000000001000,
		S_ADD_RD  = 12'b000000010000,
		S_ADD_WR  = 12'b000000100000,
		S_BLD_RD  = 12'b000001000000,
		S_BLD_SUM = 12'b000010000000,
		S_BLD_DIV = 12'b000100000000,
		S_BLD_WR  = 12'b001000000000,
		S_RD_REQ  = 12'b010000000000,
		S_RD_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] min_q [3];
	logic [15:0] max_q [3];
	logic [31:0] apt_q;
	logic [1:0]  ciu_q;

	// latched item
	logic [1:0]    ch_q;
	logic [15:0]   pix_q;
	logic [7:0]    idx_q;
	logic          rd_ok_q;

	logic [BW-1:0]  bin_q;
	logic [BW-1:0]  i_q;
	logic [CHW-1:0] k_q;
	logic [SW-1:0]  sum_q;
	logic [7:0]     e_q;
	logic [AW-1:0]  clr_q;
	logic           built_q;

	logic       out_valid_q;
	logic [7:0] lut_q;
	logic       tr_q;

	// divider
	logic             div_start, div_busy, div_done;
	logic [DIV_W-1:0] div_num, div_den;
	logic [SCW-1:0]   div_steps;
	logic [QW-1:0]    div_quo;

	// store
	store_ctl_t             st_ctl;
	logic [AW-1:0]          st_addr;
	logic [COUNT_WIDTH-1:0] h_wdata, h_rdata;
	logic [7:0]             l_wdata, l_rdata;

	logic [15:0]      lo, hi;
	logic [DIV_W-1:0] pix_total;
	logic [CHW-1:0]   last_ch;
	logic [SW-1:0]    sum_n;
	logic             ch_in_range, add_ok, out_load;
	logic             accept;

	assign accept      = in_valid && in_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign lo          = (ch_q == 2'd3) ? 16'd0 : min_q[ch_q];
	assign hi          = (ch_q == 2'd3) ? 16'd0 : max_q[ch_q];
	assign pix_total   = (apt_q == '0) ? DIV_W'(1) : apt_q;
	assign last_ch     = (ciu_q >= 2'd2) ? CHW'(CHANNELS - 1) : '0;
	assign sum_n       = sum_q + SW'(h_rdata);
	assign ch_in_range = (32'(channel) < CHANNELS);
	assign add_ok      = ch_in_range && ((ciu_q >= 2'd2) || (channel == 2'd0));
	assign out_load    = (state_q == S_RD_OUT) && (!out_valid_q || out_ready);

	// config writes, taken in any state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				min_q[c] <= 16'd0;
				max_q[c] <= 16'hFFFF;
			end
			apt_q <= 32'd1;
			ciu_q <= 2'd3;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_RED:    min_q[0] <= cfg_data[15:0];
				REG_MAX_RED:    max_q[0] <= cfg_data[15:0];
				REG_MIN_GREEN:  min_q[1] <= cfg_data[15:0];
				REG_MAX_GREEN:  max_q[1] <= cfg_data[15:0];
				REG_MIN_BLUE:   min_q[2] <= cfg_data[15:0];
				REG_MAX_BLUE:   max_q[2] <= cfg_data[15:0];
				REG_ACTIVE_TOT: apt_q    <= cfg_data[31:0];
				REG_CHAN_USE:   ciu_q    <= cfg_data[1:0];
				default:        ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			built_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						unique case (action_t'(action))
							ACT_ADD:   state_q <= add_ok ? S_ADD_SET : S_IDLE;
							ACT_BUILD: state_q <= S_BLD_RD;
							ACT_READ:  state_q <= S_RD_REQ;
							ACT_CLEAR: begin
								state_q <= S_CLEAR;
								clr_q   <= '0;
								built_q <= 1'b0;
							end
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD_SET: begin
					// samples at or outside the window edges, or an empty window, settle without the divider
					if (hi <= lo || pix_q <= lo || pix_q >= hi) begin
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_ADD_DIV;
					end
				end
				S_ADD_DIV: if (div_done) state_q <= S_ADD_RD;
				S_ADD_RD:  state_q <= S_ADD_WR;
				S_ADD_WR:  state_q <= S_IDLE;
				S_BLD_RD:  state_q <= S_BLD_SUM;
				S_BLD_SUM: begin
					if (CMPW'(sum_n) >= CMPW'(pix_total)) begin
						state_q <= S_BLD_WR;
					end else begin
						state_q <= S_BLD_DIV;
					end
				end
				S_BLD_DIV: if (div_done) state_q <= S_BLD_WR;
				S_BLD_WR: begin
					if (i_q == BW'(BINS - 1) && k_q == last_ch) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BLD_RD;
					end
				end
				S_RD_REQ: state_q <= S_RD_OUT;
				S_RD_OUT: if (out_load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// item and build datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= channel;
			pix_q   <= pixel_value;
			idx_q   <= bin_index;
			rd_ok_q <= ch_in_range && (32'(bin_index) < BINS);
			i_q     <= '0;
			k_q     <= '0;
			sum_q   <= '0;
		end
		if (state_q == S_ADD_SET) begin
			bin_q <= (hi <= lo || pix_q <= lo) ? '0 : BW'(BINS - 1);
		end
		if (state_q == S_ADD_DIV && div_done) begin
			bin_q <= div_quo[BW-1:0];
		end
		if (state_q == S_BLD_SUM) begin
			sum_q <= sum_n;
			e_q   <= OUT_MAX;
		end
		if (state_q == S_BLD_DIV && div_done) begin
			e_q <= div_quo[7:0];
		end
		if (state_q == S_BLD_WR) begin
			if (i_q == BW'(BINS - 1)) begin
				i_q   <= '0;
				sum_q <= '0;
				k_q   <= k_q + CHW'(1);
			end else begin
				i_q <= i_q + BW'(1);
			end
		end
	end

	// divider launch: sample bin, or scaled running sum
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DIV_W'(1);
		div_steps = SCW'(8);
		if (state_q == S_ADD_SET) begin
			div_start = !(hi <= lo || pix_q <= lo || pix_q >= hi);
			div_num   = DIV_W'(pix_q - lo);
			div_den   = DIV_W'(hi - lo);
			div_steps = SCW'(BW);
		end else if (state_q == S_BLD_SUM) begin
			div_start = !(CMPW'(sum_n) >= CMPW'(pix_total));
			div_num   = sum_n[DIV_W-1:0];
			div_den   = pix_total;
		end
	end

	// memory commands
	always_comb begin
		st_ctl  = '0;
		st_addr = clr_q;
		h_wdata = '0;
		l_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				st_ctl.h_wr = 1'b1;
				st_ctl.l_wr = 1'b1;
			end
			S_ADD_RD: begin
				st_ctl.h_rd = 1'b1;
				st_addr     = {ch_q[CHW-1:0], bin_q};
			end
			S_ADD_WR: begin
				// saturate at the top count
				st_ctl.h_wr = 1'b1;
				st_addr     = {ch_q[CHW-1:0], bin_q};
				h_wdata     = (&h_rdata) ? h_rdata : h_rdata + COUNT_WIDTH'(1);
			end
			S_BLD_RD: begin
				st_ctl.h_rd = 1'b1;
				st_addr     = {k_q, i_q};
			end
			S_BLD_WR: begin
				st_ctl.l_wr = 1'b1;
				st_addr     = {k_q, i_q};
				l_wdata     = e_q;
			end
			S_RD_REQ: begin
				st_ctl.l_rd = rd_ok_q;
				st_addr     = {ch_q[CHW-1:0], BW'(idx_q)};
			end
			default: ;
		endcase
	end

	// result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lut_q <= rd_ok_q ? l_rdata : 8'd0;
			tr_q  <= built_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign lut_value   = lut_q;
	assign table_ready = tr_q;

	hele_div #(
		.QW  (QW),
		.SCW (SCW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	hele_store #(
		.AW    (AW),
		.DEPTH (DEPTH),
		.CW    (COUNT_WIDTH)
	) u_store (
		.clk     (clk),
		.ctl     (st_ctl),
		.addr    (st_addr),
		.h_wdata (h_wdata),
		.l_wdata (l_wdata),
		.h_rdata (h_rdata),
		.l_rdata (l_rdata)
	);

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("item taken while divider busy");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RD_OUT))
		else $error("result raised outside read path");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_WR) |-> $past(state_q == S_ADD_RD))
		else $error("histogram write without preceding read");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		st_ctl.h_wr |-> !st_ctl.h_rd)
		else $error("histogram read and write in one cycle");

endmodule

### design/hele_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Expects the starting remainder below the divisor. Depends on hele_pkg.
`timescale 1ns / 1ps

module hele_div #(
	parameter int QW  = 8,
	parameter int SCW = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hele_pkg::DIV_W-1:0]  num,
	input  logic [hele_pkg::DIV_W-1:0]  den,
	input  logic [SCW-1:0]              steps,
	output logic                        busy,
	output logic                        done,
	output logic [QW-1:0]               quo
);
	import hele_pkg::*;

	logic             busy_q, done_q;
	logic [SCW-1:0]   cnt_q;
	logic [DIV_W-1:0] rem_q, den_q;
	logic [QW-1:0]    quo_q;
	logic [DIV_W:0]   rem2;
	logic             ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == SCW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			cnt_q <= steps;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_W'(rem2 - {1'b0, den_q}) : rem2[DIV_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
			cnt_q <= cnt_q - SCW'(1);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

### design/hele_store.sv
// Histogram and lookup-table memories, one shared address, registered reads.
// Depends on hele_pkg for the command struct.
`timescale 1ns / 1ps

module hele_store #(
	parameter int AW    = 10,
	parameter int DEPTH = 768,
	parameter int CW    = 32
) (
	input  logic                   clk,
	input  hele_pkg::store_ctl_t   ctl,
	input  logic [AW-1:0]          addr,
	input  logic [CW-1:0]          h_wdata,
	input  logic [7:0]             l_wdata,
	output logic [CW-1:0]          h_rdata,
	output logic [7:0]             l_rdata
);
	import hele_pkg::*;

	logic [CW-1:0] hist_mem [DEPTH];
	logic [7:0]    lut_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.h_wr) begin
			hist_mem[addr] <= h_wdata;
		end
		if (ctl.h_rd) begin
			h_rdata <= hist_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.l_wr) begin
			lut_mem[addr] <= l_wdata;
		end
		if (ctl.l_rd) begin
			l_rdata <= lut_mem[addr];
		end
	end

endmodule
